>>> sv/doq_pkg.sv
// Shared types and codes for the deadline-ordered queue.
`default_nettype none
package doq_pkg;

	localparam int DOQ_CAPACITY = 16;

	localparam int TIME_W   = 32;
	localparam int HANDLE_W = 16;
	localparam int MODE_W   = 2;
	localparam int STATUS_W = 3;
	localparam int LEFT_W   = 5;

	// Input modes
	localparam logic [MODE_W-1:0] MODE_ADD   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_RUN   = 2'd1;
	localparam logic [MODE_W-1:0] MODE_FLUSH = 2'd2;

	// Result status codes
	localparam logic [STATUS_W-1:0] STAT_ADDED   = 3'd0;
	localparam logic [STATUS_W-1:0] STAT_FULL    = 3'd1;
	localparam logic [STATUS_W-1:0] STAT_EXPIRED = 3'd2;
	localparam logic [STATUS_W-1:0] STAT_NONE    = 3'd3;
	localparam logic [STATUS_W-1:0] STAT_FLUSHED = 3'd4;

	typedef struct packed {
		logic [TIME_W-1:0]   deadline;
		logic [HANDLE_W-1:0] key;
		logic [HANDLE_W-1:0] command;
	} entry_t;

	// Broadcast control for every cell of the chain
	typedef struct packed {
		logic   insert;
		logic   pop;
		entry_t ins_entry;
	} cell_ctrl_t;

endpackage
`default_nettype wire

>>> sv/doq_cell.sv
// One storage cell of the sorted chain: holds an entry, shifts on insert or pop.
`default_nettype none
module doq_cell (
	input  wire logic               clk,
	input  wire doq_pkg::cell_ctrl_t ctrl,
	input  wire logic               occupied,
	input  wire logic               prev_later,
	input  wire doq_pkg::entry_t    prev_entry,
	input  wire doq_pkg::entry_t    next_entry,
	output doq_pkg::entry_t         entry,
	output logic                    later
);
	import doq_pkg::*;

	entry_t entry_q;

	assign entry = entry_q;

	// Flag a cell whose entry must move back for the new one
	assign later = !occupied || (entry_q.deadline > ctrl.ins_entry.deadline);

	// Take the new entry at the boundary, shift back behind it, shift forward on pop
	always_ff @(posedge clk) begin
		if (ctrl.insert && later) begin
			entry_q <= prev_later ? prev_entry : ctrl.ins_entry;
		end else if (ctrl.pop) begin
			entry_q <= next_entry;
		end
	end

endmodule
`default_nettype wire

>>> sv/deadline_ordered_queue.sv
// Top level of the deadline-ordered queue: cell chain plus command sequencer.
//
// Usage: drive mode, event_time, key_handle and command_handle and raise start;
// the item is taken at a rising edge where start is high and busy is low.
// An add places the entry before the first held entry with a later deadline;
// its single result (added or dropped full) appears with done in the cycle
// after acceptance. busy stays low, so adds may come back to back. A run
// or flush raises busy and pops one entry per cycle from the head of the
// chain, giving one result per cycle; a run with no due entry, or a flush
// of an empty queue, still gives one result. busy drops in the cycle the
// result marked last is shown. Every cell compares its deadline with the
// new one in parallel, so the insert time does not grow with the fill.
// Each result is on the ports for one cycle with done high; the receiver
// cannot stall and must take it then.
// Mode three is ignored and gives no result. Reset empties the queue
// (the occupancy count clears; cell contents are not cleared) and drops
// any run in progress.
`default_nettype none
module deadline_ordered_queue #(
	parameter int CAPACITY = doq_pkg::DOQ_CAPACITY
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	output logic                                busy,
	input  wire logic [doq_pkg::MODE_W-1:0]     mode,
	input  wire logic [doq_pkg::TIME_W-1:0]     event_time,
	input  wire logic [doq_pkg::HANDLE_W-1:0]   key_handle,
	input  wire logic [doq_pkg::HANDLE_W-1:0]   command_handle,
	output logic                                done,
	output logic [doq_pkg::STATUS_W-1:0]        status,
	output logic [doq_pkg::TIME_W-1:0]          entry_time,
	output logic [doq_pkg::HANDLE_W-1:0]        entry_key,
	output logic [doq_pkg::HANDLE_W-1:0]        entry_command,
	output logic [doq_pkg::LEFT_W-1:0]          entries_left,
	output logic                                last
);
	import doq_pkg::*;

	localparam int OCC_W = $clog2(CAPACITY + 1);
	localparam logic [OCC_W-1:0] OCC_FULL = OCC_W'(CAPACITY);
	localparam logic [OCC_W-1:0] OCC_ONE  = OCC_W'(1);

	localparam logic ST_IDLE  = 1'b0;
	localparam logic ST_DRAIN = 1'b1;

	logic              state_q;
	logic [OCC_W-1:0]  occ_q;
	logic [TIME_W-1:0] time_q;
	logic              flush_q;

	logic              done_q;
	logic [STATUS_W-1:0] status_q;
	entry_t            out_entry_q;
	logic [LEFT_W-1:0] left_q;
	logic              last_q;

	cell_ctrl_t        ctrl;
	entry_t            cell_entry [CAPACITY];
	logic              cell_later [CAPACITY];

	logic accept, do_add, full, due0, more, do_pop;

	assign accept = start && (state_q == ST_IDLE);
	assign full   = (occ_q >= OCC_FULL);
	assign do_add = accept && (mode == MODE_ADD) && !full;

	// Head checks during a run or flush
	assign due0 = (occ_q != '0) && (flush_q || (cell_entry[0].deadline <= time_q));
	assign more = (occ_q > OCC_ONE) && (flush_q || (cell_entry[1].deadline <= time_q));
	assign do_pop = (state_q == ST_DRAIN) && due0;

	assign ctrl.insert              = do_add;
	assign ctrl.pop                 = do_pop;
	assign ctrl.ins_entry.deadline  = event_time;
	assign ctrl.ins_entry.key       = key_handle;
	assign ctrl.ins_entry.command   = command_handle;

	// Build the chain of cells, head at index zero
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic   occupied;
		logic   prev_later;
		entry_t prev_entry;
		entry_t next_entry;

		assign occupied = (occ_q > OCC_W'(i));

		if (i == 0) begin : g_head
			assign prev_later = 1'b1;
			assign prev_entry = ctrl.ins_entry;
		end else begin : g_body
			assign prev_later = cell_later[i-1];
			assign prev_entry = cell_entry[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign next_entry = cell_entry[i];
		end else begin : g_mid
			assign next_entry = cell_entry[i+1];
		end

		doq_cell u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.occupied   (occupied),
			.prev_later (prev_later),
			.prev_entry (prev_entry),
			.next_entry (next_entry),
			.entry      (cell_entry[i]),
			.later      (cell_later[i])
		);
	end

	// Sequence commands and track occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			occ_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (mode == MODE_ADD) begin
							done_q <= 1'b1;
							if (!full) begin
								occ_q <= occ_q + OCC_ONE;
							end
						end else if (mode == MODE_RUN || mode == MODE_FLUSH) begin
							state_q <= ST_DRAIN;
						end
					end
				end
				ST_DRAIN: begin
					done_q <= 1'b1;
					if (due0) begin
						occ_q <= occ_q - OCC_ONE;
						if (!more) begin
							state_q <= ST_IDLE;
						end
					end else begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Hold the run parameters and load the result registers
	always_ff @(posedge clk) begin
		if (accept) begin
			time_q  <= event_time;
			flush_q <= (mode == MODE_FLUSH);
		end
		if (state_q == ST_IDLE) begin
			status_q    <= full ? STAT_FULL : STAT_ADDED;
			out_entry_q <= ctrl.ins_entry;
			left_q      <= LEFT_W'(full ? occ_q : occ_q + OCC_ONE);
			last_q      <= 1'b1;
		end else if (due0) begin
			status_q    <= flush_q ? STAT_FLUSHED : STAT_EXPIRED;
			out_entry_q <= cell_entry[0];
			left_q      <= LEFT_W'(occ_q - OCC_ONE);
			last_q      <= !more;
		end else begin
			status_q    <= STAT_NONE;
			out_entry_q <= '0;
			left_q      <= LEFT_W'(occ_q);
			last_q      <= 1'b1;
		end
	end

	assign busy          = (state_q == ST_DRAIN);
	assign done          = done_q;
	assign status        = status_q;
	assign entry_time    = out_entry_q.deadline;
	assign entry_key     = out_entry_q.key;
	assign entry_command = out_entry_q.command;
	assign entries_left  = left_q;
	assign last          = last_q;

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= OCC_FULL)
		else $error("occupancy above capacity");

	a_last_frees: assert property (@(posedge clk) disable iff (!arst_n)
		done && last |-> !busy)
		else $error("still busy after final result");

	a_more_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done && !last |-> busy)
		else $error("non-final result outside a drain");

	a_add_count: assert property (@(posedge clk) disable iff (!arst_n)
		do_add |=> occ_q == $past(occ_q) + OCC_ONE)
		else $error("insert did not grow occupancy");

	a_pop_count: assert property (@(posedge clk) disable iff (!arst_n)
		do_pop |=> occ_q == $past(occ_q) - OCC_ONE)
		else $error("pop did not shrink occupancy");

endmodule
`default_nettype wire
